@@ src/avb_pkg.sv @@
// Shared types, constants and the arctangent table of the vector angle block.
package avb_pkg;

   localparam int COMPONENT_BITS  = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int PROD_BITS       = 2 * COMPONENT_BITS;
   localparam int MAG_BITS        = PROD_BITS + 1;
   localparam int ANG_SCALE_BITS  = 24;
   localparam int CORDIC_STEPS    = 30;
   localparam int XY_BITS         = MAG_BITS + 3;
   localparam int Z_BITS          = 34;
   localparam int ROUND_SHIFT     = ANG_SCALE_BITS - ANGLE_FRAC_BITS;
   localparam int ANGLE_BITS      = 16;

   localparam logic signed [Z_BITS-1:0] QUARTER_TURN = Z_BITS'(90) <<< ANG_SCALE_BITS;
   localparam logic signed [Z_BITS-1:0] HALF_TURN    = Z_BITS'(180) <<< ANG_SCALE_BITS;

   // atan(2^-i) in degrees, scaled by 2^24.
   localparam logic signed [Z_BITS-1:0] ATAN_DEG_TAB [CORDIC_STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466,
      938734, 469367, 234684, 117342, 58671,
      29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57,
      29, 14, 7, 4, 2
   };

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] first_x;
      logic signed [COMPONENT_BITS-1:0] first_y;
      logic signed [COMPONENT_BITS-1:0] second_x;
      logic signed [COMPONENT_BITS-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_degrees;
      logic                  zero_length;
   } rsp_type;

   // Classified work item handed from the front end to the CORDIC back end.
   typedef struct packed {
      logic                zero_length;
      logic                dot_neg;
      logic                dot_zero;
      logic                cross_zero;
      logic [MAG_BITS-1:0] dot_mag;
      logic [MAG_BITS-1:0] cross_mag;
   } item_type;

   // Flags that ride along the CORDIC pipeline.
   typedef struct packed {
      logic zero_length;
      logic dot_neg;
      logic dot_zero;
      logic cross_zero;
   } flags_type;

endpackage

@@ src/avb_front.sv @@
// Front end: products, dot and cross sums, and classification of each pair.
module avb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  avb_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_ready,
   output avb_pkg::item_type item_data
);

   localparam int PB = avb_pkg::PROD_BITS;
   localparam int MB = avb_pkg::MAG_BITS;

   logic                 s1_valid_ff, s2_valid_ff;
   logic                 advance;
   logic signed [PB-1:0] axbx_ff, ayby_ff, axby_ff, aybx_ff;
   logic                 zero_ff;
   avb_pkg::item_type    item_ff, item_in;
   logic signed [MB-1:0] dot_s, cross_s;

   assign advance   = !s2_valid_ff || item_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         axbx_ff <= req_data.first_x * req_data.second_x;
         ayby_ff <= req_data.first_y * req_data.second_y;
         axby_ff <= req_data.first_x * req_data.second_y;
         aybx_ff <= req_data.first_y * req_data.second_x;
         zero_ff <= ((req_data.first_x == '0) && (req_data.first_y == '0)) ||
                    ((req_data.second_x == '0) && (req_data.second_y == '0));
         item_ff <= item_in;
      end
   end

   always_comb begin
      dot_s   = MB'(axbx_ff) + MB'(ayby_ff);
      cross_s = MB'(axby_ff) - MB'(aybx_ff);
      item_in.zero_length = zero_ff;
      item_in.dot_neg     = dot_s[MB-1];
      item_in.dot_zero    = (dot_s == '0);
      item_in.cross_zero  = (cross_s == '0);
      item_in.dot_mag     = dot_s[MB-1] ? MB'(-dot_s) : MB'(dot_s);
      item_in.cross_mag   = cross_s[MB-1] ? MB'(-cross_s) : MB'(cross_s);
   end

   assign item_valid = s2_valid_ff;
   assign item_data  = item_ff;

endmodule

@@ src/avb_queue.sv @@
// Two-entry queue between the front end and the CORDIC back end.
module avb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  avb_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output avb_pkg::item_type pop_data
);

   avb_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/avb_back.sv @@
// Back end: pipelined vectoring CORDIC, quadrant fix-up and rounding.
module avb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  avb_pkg::item_type item_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output avb_pkg::rsp_type  rsp_data
);

   localparam int N  = avb_pkg::CORDIC_STEPS;
   localparam int XW = avb_pkg::XY_BITS;
   localparam int ZW = avb_pkg::Z_BITS;
   localparam int SH = avb_pkg::ROUND_SHIFT;

   logic                 advance;
   logic [N:0]           valid_ff;
   logic signed [XW-1:0] x_ff [N+1];
   logic signed [XW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   avb_pkg::flags_type   flags_ff [N+1];
   logic                 out_valid_ff;
   avb_pkg::rsp_type     out_ff, out_in;

   logic signed [ZW-1:0] z_clamp, phi, angle;
   logic [ZW-1:0]        rounded;

   assign advance    = !out_valid_ff || rsp_ready;
   assign item_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[N-1:0], item_valid};
         out_valid_ff <= valid_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]                 <= XW'(item_data.dot_mag);
         y_ff[0]                 <= XW'(item_data.cross_mag);
         z_ff[0]                 <= '0;
         flags_ff[0].zero_length <= item_data.zero_length;
         flags_ff[0].dot_neg     <= item_data.dot_neg;
         flags_ff[0].dot_zero    <= item_data.dot_zero;
         flags_ff[0].cross_zero  <= item_data.cross_zero;
         out_ff                  <= out_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            flags_ff[i+1] <= flags_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + avb_pkg::ATAN_DEG_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - avb_pkg::ATAN_DEG_TAB[i];
            end
         end
      end
   end

   always_comb begin
      if (z_ff[N] < 0) begin
         z_clamp = '0;
      end else if (z_ff[N] > avb_pkg::QUARTER_TURN) begin
         z_clamp = avb_pkg::QUARTER_TURN;
      end else begin
         z_clamp = z_ff[N];
      end
      priority if (flags_ff[N].cross_zero) begin
         phi = '0;
      end else if (flags_ff[N].dot_zero) begin
         phi = avb_pkg::QUARTER_TURN;
      end else begin
         phi = z_clamp;
      end
      angle   = flags_ff[N].dot_neg ? (avb_pkg::HALF_TURN - phi) : phi;
      rounded = (ZW'(angle) + (ZW'(1) << (SH - 1))) >> SH;
      out_in.zero_length = flags_ff[N].zero_length;
      if (flags_ff[N].zero_length) begin
         out_in.angle_degrees = '0;
      end else if (rounded > ZW'(16'hFFFF)) begin
         out_in.angle_degrees = '1;
      end else begin
         out_in.angle_degrees = rounded[avb_pkg::ANGLE_BITS-1:0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ src/angle_between_vectors.sv @@
// Throughput: one vector pair per cycle while rsp_ready is high; the front end (two stages),
// the queue and the 30-stage CORDIC pipeline each advance every cycle unless a stall holds them.
// Reset: synchronous, active high; it empties the pipelines and the queue.
// The block keeps no state between items.
module angle_between_vectors (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  avb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output avb_pkg::rsp_type rsp_data
);

   // The front end multiplies the components, forms the dot and cross products
   // and classifies the pair (zero vector, parallel, perpendicular or general).
   // Its classified items pass through a two-entry queue, so a stall at the
   // result side does not reach the input side at once. The back end then runs
   // a vectoring CORDIC on the magnitudes to find the first-quadrant angle,
   // mirrors it when the dot product is negative and rounds to the output scale.
   logic              item_valid_f, item_ready_f;
   logic              item_valid_b, item_ready_b;
   avb_pkg::item_type item_f, item_b;

   avb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid_f),
      .item_ready (item_ready_f),
      .item_data  (item_f)
   );

   avb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (item_valid_f),
      .push_ready (item_ready_f),
      .push_data  (item_f),
      .pop_valid  (item_valid_b),
      .pop_ready  (item_ready_b),
      .pop_data   (item_b)
   );

   // The whole back-end pipeline holds while a finished result waits on the
   // output register; bubbles travel through it like ordinary items.
   avb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_b),
      .item_ready (item_ready_b),
      .item_data  (item_b),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
